/* rtl/core/hmf_pkg.sv */
// Shared types and constants of the histogram mode finder.
`default_nettype none

package hmf_pkg;

  // Default configuration of the histogram.
  localparam int NUM_BINS_DEF   = 1024;
  localparam int COUNT_BITS_DEF = 16;

  // Field widths on the stream ports.
  localparam int SAMPLE_W     = 16;
  localparam int MODE_VALUE_W = 11;
  localparam int MODE_COUNT_W = 16;
  localparam int IN_TDATA_W   = 16;
  localparam int OUT_TDATA_W  = 32;
  localparam int OUT_PAD_W    = OUT_TDATA_W - MODE_VALUE_W - MODE_COUNT_W - 2;

  typedef enum logic {
    OP_ADD    = 1'b0,
    OP_REPORT = 1'b1
  } opcode_e;

  // Control bits of the word held in the read stage.
  typedef struct packed {
    logic valid;
    logic report;
    logic in_range;
  } stage_ctl_t;

endpackage

`default_nettype wire

/* rtl/core/hmf_bin_ram.sv */
// Single-clock bin count memory with one write port and one registered read port.
`default_nettype none

module hmf_bin_ram #(
  parameter int DEPTH  = hmf_pkg::NUM_BINS_DEF,
  parameter int ADDR_W = $clog2(hmf_pkg::NUM_BINS_DEF),
  parameter int DATA_W = hmf_pkg::COUNT_BITS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              wr_en_i,
  input  wire logic [ADDR_W-1:0] wr_addr_i,
  input  wire logic [DATA_W-1:0] wr_data_i,
  input  wire logic              rd_en_i,
  input  wire logic [ADDR_W-1:0] rd_addr_i,
  output logic      [DATA_W-1:0] rd_data_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // A read at the address being written returns the old contents.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

/* rtl/core/hmf_update.sv */
// Count increment with write forwarding and running mode tracking.
`default_nettype none

module hmf_update #(
  parameter int COUNT_BITS = hmf_pkg::COUNT_BITS_DEF,
  parameter int IDX_W      = $clog2(hmf_pkg::NUM_BINS_DEF),
  parameter int VAL_W      = $clog2(hmf_pkg::NUM_BINS_DEF + 1)
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire hmf_pkg::stage_ctl_t    ctl_i,
  input  wire logic [IDX_W-1:0]       slot_i,
  input  wire logic [VAL_W-1:0]       value_i,
  input  wire logic [COUNT_BITS-1:0]  rd_data_i,
  output logic                        wr_en_o,
  output logic      [IDX_W-1:0]       wr_addr_o,
  output logic      [COUNT_BITS-1:0]  wr_data_o,
  output logic      [COUNT_BITS-1:0]  best_count_o,
  output logic      [VAL_W-1:0]       best_value_o
);

  logic                  last_valid_q, last_valid_d;
  logic [IDX_W-1:0]      last_addr_q;
  logic [COUNT_BITS-1:0] last_data_q;
  logic [COUNT_BITS-1:0] best_count_q, best_count_d;
  logic [VAL_W-1:0]      best_value_q, best_value_d;

  logic                  sample_go;
  logic [COUNT_BITS-1:0] cnt_old;
  logic [COUNT_BITS-1:0] cnt_new;

  assign sample_go = ctl_i.valid && !ctl_i.report && ctl_i.in_range;

  // The memory read was issued at the same edge as the previous write, so a
  // back-to-back hit on one bin takes the count from the last write instead.
  assign cnt_old = (last_valid_q && (last_addr_q == slot_i)) ? last_data_q : rd_data_i;
  assign cnt_new = (&cnt_old) ? cnt_old : cnt_old + COUNT_BITS'(1);

  assign wr_en_o   = sample_go;
  assign wr_addr_o = slot_i;
  assign wr_data_o = cnt_new;

  always_comb begin
    best_count_d = best_count_q;
    best_value_d = best_value_q;
    if (sample_go) begin
      if (cnt_new > best_count_q) begin
        best_count_d = cnt_new;
        best_value_d = value_i;
      end else if ((cnt_new == best_count_q) && (value_i < best_value_q)) begin
        best_value_d = value_i;
      end
    end
  end

  assign last_valid_d = sample_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_valid_q <= 1'b0;
      best_count_q <= '0;
      best_value_q <= '0;
    end else begin
      last_valid_q <= last_valid_d;
      best_count_q <= best_count_d;
      best_value_q <= best_value_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sample_go) begin
      last_addr_q <= slot_i;
      last_data_q <= cnt_new;
    end
  end

  assign best_count_o = best_count_q;
  assign best_value_o = best_value_q;

endmodule

`default_nettype wire

/* rtl/core/histogram_mode_finder.sv */
// Top level of the histogram mode finder: stream ports, clearing pass and result register.
`default_nettype none

// Samples are counted in a bin memory of NUM_BINS entries with a registered
// read port; the read of the bin is issued when a word is accepted and the
// incremented count is written back from the read stage in the next cycle,
// with forwarding from the last write, so a sample word is taken in every
// cycle once the clearing pass is done. A report word is taken when the
// result register is free or being read in that cycle and no other report is
// in the read stage; its result passes through the read stage into the result
// register and waits there while samples keep flowing. After reset the block
// clears the bin memory one entry a cycle and accepts nothing during that pass.
// The input tuser bit selects the operation (0 counts the sample, 1 asks for
// the mode); samples of 0 or above NUM_BINS are dropped and set a sticky flag.
module histogram_mode_finder #(
  parameter int NUM_BINS   = hmf_pkg::NUM_BINS_DEF,
  parameter int COUNT_BITS = hmf_pkg::COUNT_BITS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // [15:0] sample_value
  input  wire logic [hmf_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  // [0] opcode
  input  wire logic [0:0]                      s_axis_tuser_i,
  output logic                                 m_axis_tvalid_o,
  input  wire logic                            m_axis_tready_i,
  // [10:0] mode_value, [26:11] mode_count, [27] no_samples, [28] dropped_seen
  output logic      [hmf_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o
);

  localparam int IDX_W     = $clog2(NUM_BINS);
  localparam int VAL_W_RAW = $clog2(NUM_BINS + 1);
  localparam int VAL_W     = (VAL_W_RAW > hmf_pkg::SAMPLE_W) ? hmf_pkg::SAMPLE_W : VAL_W_RAW;

  // Clearing pass.
  logic             clr_busy_q, clr_busy_d;
  logic [IDX_W-1:0] clr_idx_q, clr_idx_d;

  // Read stage.
  hmf_pkg::stage_ctl_t s1_ctl_q, s1_ctl_d;
  logic [IDX_W-1:0]    s1_slot_q;
  logic [VAL_W-1:0]    s1_value_q;

  logic dropped_q, dropped_d;

  // Result register.
  logic                            out_valid_q, out_valid_d;
  logic [hmf_pkg::OUT_TDATA_W-1:0] out_data_q;
  logic [hmf_pkg::OUT_TDATA_W-1:0] out_word;

  logic                             in_accept;
  logic                             in_is_report;
  logic [hmf_pkg::SAMPLE_W-1:0]     sample;
  logic [hmf_pkg::SAMPLE_W:0]       slot_full;
  logic                             sample_in_range;
  logic                             s1_report;

  logic                  upd_wr_en;
  logic [IDX_W-1:0]      upd_wr_addr;
  logic [COUNT_BITS-1:0] upd_wr_data;
  logic [COUNT_BITS-1:0] best_count;
  logic [VAL_W-1:0]      best_value;
  logic [COUNT_BITS-1:0] rd_data;

  logic                  ram_wr_en;
  logic [IDX_W-1:0]      ram_wr_addr;
  logic [COUNT_BITS-1:0] ram_wr_data;

  logic [31:0]                       best_count_ext;
  logic [31:0]                       best_value_ext;
  logic [hmf_pkg::MODE_COUNT_W-1:0]  mode_count;
  logic                              no_samples;

  assign sample          = s_axis_tdata_i[hmf_pkg::SAMPLE_W-1:0];
  assign in_is_report    = (hmf_pkg::opcode_e'(s_axis_tuser_i[0]) == hmf_pkg::OP_REPORT);
  assign slot_full       = {1'b0, sample} - {{hmf_pkg::SAMPLE_W{1'b0}}, 1'b1};
  assign sample_in_range = (sample != '0) && (32'(sample) <= 32'(NUM_BINS));
  assign s1_report       = s1_ctl_q.valid && s1_ctl_q.report;

  // A report needs the result register to be free by the time it leaves the
  // read stage; sample words never wait on the output side.
  assign s_axis_tready_o = !clr_busy_q &&
                           (!in_is_report || ((!out_valid_q || m_axis_tready_i) && !s1_report));
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_idx_d  = clr_idx_q;
    if (clr_busy_q) begin
      clr_idx_d = clr_idx_q + IDX_W'(1);
      if (clr_idx_q == IDX_W'(NUM_BINS - 1)) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  always_comb begin
    s1_ctl_d.valid    = in_accept;
    s1_ctl_d.report   = in_is_report;
    s1_ctl_d.in_range = sample_in_range;
  end

  assign dropped_d = dropped_q ||
                     (s1_ctl_q.valid && !s1_ctl_q.report && !s1_ctl_q.in_range);

  assign ram_wr_en   = clr_busy_q || upd_wr_en;
  assign ram_wr_addr = clr_busy_q ? clr_idx_q : upd_wr_addr;
  assign ram_wr_data = clr_busy_q ? '0 : upd_wr_data;

  hmf_bin_ram #(
    .DEPTH  (NUM_BINS),
    .ADDR_W (IDX_W),
    .DATA_W (COUNT_BITS)
  ) u_bin_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_wr_en),
    .wr_addr_i (ram_wr_addr),
    .wr_data_i (ram_wr_data),
    .rd_en_i   (in_accept),
    .rd_addr_i (slot_full[IDX_W-1:0]),
    .rd_data_o (rd_data)
  );

  hmf_update #(
    .COUNT_BITS (COUNT_BITS),
    .IDX_W      (IDX_W),
    .VAL_W      (VAL_W)
  ) u_update (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (s1_ctl_q),
    .slot_i       (s1_slot_q),
    .value_i      (s1_value_q),
    .rd_data_i    (rd_data),
    .wr_en_o      (upd_wr_en),
    .wr_addr_o    (upd_wr_addr),
    .wr_data_o    (upd_wr_data),
    .best_count_o (best_count),
    .best_value_o (best_value)
  );

  assign best_count_ext = 32'(best_count);
  assign best_value_ext = 32'(best_value);
  assign mode_count     = (best_count_ext > 32'h0000_FFFF) ? '1 :
                          best_count_ext[hmf_pkg::MODE_COUNT_W-1:0];
  assign no_samples     = (best_count == '0);
  assign out_word       = {{hmf_pkg::OUT_PAD_W{1'b0}}, dropped_q, no_samples, mode_count,
                           best_value_ext[hmf_pkg::MODE_VALUE_W-1:0]};

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
    if (s1_report) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q  <= 1'b1;
      clr_idx_q   <= '0;
      s1_ctl_q    <= '0;
      dropped_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      clr_busy_q  <= clr_busy_d;
      clr_idx_q   <= clr_idx_d;
      s1_ctl_q    <= s1_ctl_d;
      dropped_q   <= dropped_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_slot_q  <= slot_full[IDX_W-1:0];
      s1_value_q <= sample[VAL_W-1:0];
    end
    if (s1_report) begin
      out_data_q <= out_word;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // Nothing is accepted while the bin memory is being cleared.
  a_no_accept_in_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> !in_accept)
    else $error("word accepted during the clearing pass");

  // A report leaving the read stage always finds the result register empty.
  a_result_slot_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_report |-> !out_valid_q)
    else $error("report result would overwrite a pending result");

  // An empty histogram has no mode value.
  a_empty_mode : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (best_count == '0) |-> (best_value == '0))
    else $error("mode value set without any counted sample");

  // The drop flag never clears outside reset.
  a_dropped_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    dropped_q |=> dropped_q)
    else $error("drop flag cleared");

endmodule

`default_nettype wire
